@@ rtl/mcs_pkg.sv @@
// shared constants, state and command types for the multiscale contrast saliency block
// no dependencies; compiled first
package mcs_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int REG_W     = 9;
    localparam int OFF_W     = 10;
    localparam int EXT_W     = 9;
    localparam int SMP_W     = 16;
    localparam int PIX_W     = 3 * SMP_W;
    localparam int A_W       = 13;
    localparam int A2_W      = 25;
    localparam int SUM_W     = 29;
    localparam int PROD_W    = 30;
    localparam int MAG_W     = 29;
    localparam int TOT_W     = 60;
    localparam int FRAC_W    = 8;
    localparam int DVD_W     = TOT_W + FRAC_W;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam int SAL_W     = 44;
    localparam int N_SCALES  = 3;
    localparam int N_CH      = 3;
    localparam int IDX_W     = 2;
    localparam int SCALE_DIV = 8;
    localparam int HALVE     = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_OWN,
        ST_SWEEP,
        ST_DRAIN,
        ST_AREA2,
        ST_MULV,
        ST_SUB,
        ST_SQ,
        ST_DIVINIT,
        ST_DIV,
        ST_ACC,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic write;
        logic setup;
        logic own;
        logic sweep;
        logic area2;
        logic mulv;
        logic sub;
        logic sq;
        logic divinit;
        logic div_step;
        logic acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic sweep_last;
        logic ch_last;
        logic div_last;
        logic scale_last;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/mcs_ifs.sv @@
// valid/ready channel interfaces for pixel items and saliency results
// depends on mcs_pkg
interface mcs_pix_if;
    import mcs_pkg::*;
    logic             valid;
    logic             ready;
    logic             action;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic signed [SMP_W-1:0] lightness;
    logic signed [SMP_W-1:0] chroma_a;
    logic signed [SMP_W-1:0] chroma_b;

    modport source (output valid, action, pixel_row, pixel_col, lightness, chroma_a, chroma_b,
                    input ready);
    modport sink   (input valid, action, pixel_row, pixel_col, lightness, chroma_a, chroma_b,
                    output ready);
endinterface

interface mcs_sal_if;
    import mcs_pkg::*;
    logic             valid;
    logic             ready;
    logic [SAL_W-1:0] saliency;
    logic             out_of_range;

    modport source (output valid, saliency, out_of_range, input ready);
    modport sink   (input valid, saliency, out_of_range, output ready);
endinterface

@@ rtl/mcs_ctrl.sv @@
// query sequencer: steps the datapath through sweep, per-scale math and division
// depends on mcs_pkg
module mcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_action,
    input  mcs_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output mcs_pkg::t_cmd o_cmd
);
    import mcs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_action == ACT_QUERY) n_state = ST_SETUP;
            end
            ST_SETUP:   n_state = i_stat.oor ? ST_FINISH : ST_OWN;
            ST_OWN:     n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (i_stat.sweep_last) n_state = ST_DRAIN;
            end
            ST_DRAIN:   n_state = ST_AREA2;
            ST_AREA2:   n_state = ST_MULV;
            ST_MULV:    n_state = ST_SUB;
            ST_SUB:     n_state = ST_SQ;
            ST_SQ:      n_state = i_stat.ch_last ? ST_DIVINIT : ST_MULV;
            ST_DIVINIT: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_ACC;
            end
            ST_ACC:     n_state = i_stat.scale_last ? ST_FINISH : ST_AREA2;
            ST_FINISH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid && i_in_action == ACT_QUERY;
                o_cmd.write   = i_in_valid && i_in_action == ACT_LOAD;
            end
            ST_SETUP:   o_cmd.setup    = 1'b1;
            ST_OWN:     o_cmd.own      = 1'b1;
            ST_SWEEP:   o_cmd.sweep    = 1'b1;
            ST_DRAIN:   o_cmd          = '0;
            ST_AREA2:   o_cmd.area2    = 1'b1;
            ST_MULV:    o_cmd.mulv     = 1'b1;
            ST_SUB:     o_cmd.sub      = 1'b1;
            ST_SQ:      o_cmd.sq       = 1'b1;
            ST_DIVINIT: o_cmd.divinit  = 1'b1;
            ST_DIV:     o_cmd.div_step = 1'b1;
            ST_ACC:     o_cmd.acc      = 1'b1;
            ST_FINISH:  o_cmd.out_load = i_stat.out_free;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

@@ rtl/mcs_dp.sv @@
// datapath: pixel memory, window sweep accumulators, multiplier, divider, output register
// depends on mcs_pkg
module mcs_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcs_pkg::t_cmd               i_cmd,
    output mcs_pkg::t_stat              o_stat,
    input  logic [mcs_pkg::REG_W-1:0]   i_rows,
    input  logic [mcs_pkg::REG_W-1:0]   i_cols,
    input  logic [mcs_pkg::ROW_W-1:0]   i_pixel_row,
    input  logic [mcs_pkg::COL_W-1:0]   i_pixel_col,
    input  logic [mcs_pkg::SMP_W-1:0]   i_lightness,
    input  logic [mcs_pkg::SMP_W-1:0]   i_chroma_a,
    input  logic [mcs_pkg::SMP_W-1:0]   i_chroma_b,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [mcs_pkg::SAL_W-1:0]   o_saliency,
    output logic                        o_out_of_range
);
    import mcs_pkg::*;

    logic [PIX_W-1:0] mem [2**ADDR_W];
    logic [PIX_W-1:0] r_rdata;
    logic [ADDR_W-1:0] raddr;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_rb0 [N_SCALES];
    logic [ROW_W-1:0] r_rb1 [N_SCALES];
    logic [COL_W-1:0] r_cb0 [N_SCALES];
    logic [COL_W-1:0] r_cb1 [N_SCALES];
    logic [A_W-1:0]   r_area [N_SCALES];
    logic             r_oor;
    logic signed [SMP_W-1:0] r_own [N_CH];
    logic [ROW_W-1:0] r_i;
    logic [COL_W-1:0] r_j;
    logic             r_pv;
    logic             r_in [N_SCALES];
    logic signed [SUM_W-1:0] r_sum [N_SCALES][N_CH];
    logic [IDX_W-1:0] r_scale;
    logic [IDX_W-1:0] r_ch;
    logic signed [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0] r_mag;
    logic [TOT_W-1:0] r_tot;
    logic [A2_W-1:0]  r_a2;
    logic [DVD_W-1:0] r_dvd;
    logic [A2_W-1:0]  r_rem;
    logic [SAL_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [SAL_W-1:0] r_sal;
    logic             r_o_valid;
    logic [SAL_W-1:0] r_o_sal;
    logic             r_o_oor;

    // window bounds
    logic [REG_W-1:0] rows_c;
    logic [REG_W-1:0] cols_c;
    logic [REG_W-1:0] dim_min;
    logic [OFF_W-1:0] off [N_SCALES];
    logic [ROW_W-1:0] rb0 [N_SCALES];
    logic [ROW_W-1:0] rb1 [N_SCALES];
    logic [COL_W-1:0] cb0 [N_SCALES];
    logic [COL_W-1:0] cb1 [N_SCALES];
    logic [A_W-1:0]   area [N_SCALES];
    logic             oor;
    logic signed [SMP_W-1:0] rd_smp [N_CH];
    logic signed [PROD_W:0]  diff;
    logic [PROD_W:0]  diff_abs;
    logic [A2_W:0]    trial;
    logic             fits;

    always_comb begin
        rows_c = (i_rows == '0) ? REG_W'(1) :
                 (i_rows > REG_W'(MAX_ROWS)) ? REG_W'(MAX_ROWS) : i_rows;
        cols_c = (i_cols == '0) ? REG_W'(1) :
                 (i_cols > REG_W'(MAX_COLS)) ? REG_W'(MAX_COLS) : i_cols;
        dim_min = (rows_c < cols_c) ? rows_c : cols_c;
        off[0] = OFF_W'((OFF_W'(dim_min) + OFF_W'(SCALE_DIV - 1)) / SCALE_DIV);
        off[1] = OFF_W'((off[0] + OFF_W'(HALVE - 1)) / HALVE);
        off[2] = OFF_W'((off[1] + OFF_W'(HALVE - 1)) / HALVE);
        for (int k = 0; k < N_SCALES; k++) begin
            rb0[k] = (OFF_W'(r_row) > off[k]) ? ROW_W'(OFF_W'(r_row) - off[k]) : '0;
            rb1[k] = (OFF_W'(r_row) + off[k] < OFF_W'(rows_c) - OFF_W'(1)) ?
                     ROW_W'(OFF_W'(r_row) + off[k]) : ROW_W'(rows_c - REG_W'(1));
            cb0[k] = (OFF_W'(r_col) > off[k]) ? COL_W'(OFF_W'(r_col) - off[k]) : '0;
            cb1[k] = (OFF_W'(r_col) + off[k] < OFF_W'(cols_c) - OFF_W'(1)) ?
                     COL_W'(OFF_W'(r_col) + off[k]) : COL_W'(cols_c - REG_W'(1));
            area[k] = A_W'((EXT_W'(rb1[k]) - EXT_W'(rb0[k]) + EXT_W'(1))
                         * (EXT_W'(cb1[k]) - EXT_W'(cb0[k]) + EXT_W'(1)));
        end
        oor = (REG_W'(r_row) >= rows_c) || (REG_W'(r_col) >= cols_c);
    end

    assign rd_smp[0] = r_rdata[3*SMP_W-1:2*SMP_W];
    assign rd_smp[1] = r_rdata[2*SMP_W-1:SMP_W];
    assign rd_smp[2] = r_rdata[SMP_W-1:0];

    assign raddr = i_cmd.setup ? {r_row, r_col} : {r_i, r_j};

    // pixel memory: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[{i_pixel_row, i_pixel_col}] <= {i_lightness, i_chroma_a, i_chroma_b};
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        diff     = (PROD_W + 1)'(r_prod) - (PROD_W + 1)'(r_sum[r_scale][r_ch]);
        diff_abs = diff[PROD_W] ? (PROD_W + 1)'(-diff) : (PROD_W + 1)'(diff);
        trial    = {r_rem, r_dvd[DVD_W-1]};
        fits     = trial >= {1'b0, r_a2};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_pixel_row;
            r_col <= i_pixel_col;
        end
        if (i_cmd.setup) begin
            for (int k = 0; k < N_SCALES; k++) begin
                r_rb0[k]  <= rb0[k];
                r_rb1[k]  <= rb1[k];
                r_cb0[k]  <= cb0[k];
                r_cb1[k]  <= cb1[k];
                r_area[k] <= area[k];
                for (int c = 0; c < N_CH; c++) r_sum[k][c] <= '0;
            end
            r_oor   <= oor;
            r_i     <= rb0[0];
            r_j     <= cb0[0];
            r_sal   <= '0;
            r_scale <= '0;
        end
        if (i_cmd.own) begin
            for (int c = 0; c < N_CH; c++) r_own[c] <= rd_smp[c];
        end
        if (i_cmd.sweep) begin
            if (r_j == r_cb1[0]) begin
                r_j <= r_cb0[0];
                r_i <= r_i + ROW_W'(1);
            end else begin
                r_j <= r_j + COL_W'(1);
            end
        end
        // window membership of the address in flight, lined up with read data
        for (int k = 0; k < N_SCALES; k++) begin
            r_in[k] <= (r_i >= r_rb0[k]) && (r_i <= r_rb1[k])
                    && (r_j >= r_cb0[k]) && (r_j <= r_cb1[k]);
        end
        if (r_pv) begin
            for (int k = 0; k < N_SCALES; k++) begin
                if (r_in[k]) begin
                    for (int c = 0; c < N_CH; c++) begin
                        r_sum[k][c] <= r_sum[k][c] + SUM_W'(rd_smp[c]);
                    end
                end
            end
        end
        if (i_cmd.area2) begin
            r_a2  <= A2_W'(r_area[r_scale] * r_area[r_scale]);
            r_tot <= '0;
            r_ch  <= '0;
        end
        if (i_cmd.mulv) begin
            r_prod <= PROD_W'(r_own[r_ch] * $signed({1'b0, r_area[r_scale]}));
        end
        if (i_cmd.sub) begin
            r_mag <= MAG_W'(diff_abs);
        end
        if (i_cmd.sq) begin
            r_tot <= r_tot + TOT_W'(r_mag * r_mag);
            r_ch  <= r_ch + IDX_W'(1);
        end
        if (i_cmd.divinit) begin
            r_dvd <= {r_tot, FRAC_W'(0)};
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end
        // restoring division, one quotient bit per cycle
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= fits ? A2_W'(trial - {1'b0, r_a2}) : A2_W'(trial);
            r_quo <= {r_quo[SAL_W-2:0], fits};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.acc) begin
            r_sal   <= r_sal + r_quo;
            r_scale <= r_scale + IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            r_o_sal <= r_oor ? '0 : r_sal;
            r_o_oor <= r_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_pv <= i_cmd.sweep;
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.oor        = oor;
        o_stat.sweep_last = (r_i == r_rb1[0]) && (r_j == r_cb1[0]);
        o_stat.ch_last    = r_ch == IDX_W'(N_CH - 1);
        o_stat.div_last   = r_cnt == CNT_W'(DVD_W - 1);
        o_stat.scale_last = r_scale == IDX_W'(N_SCALES - 1);
        o_stat.out_free   = !r_o_valid || i_out_ready;
    end

    assign o_out_valid    = r_o_valid;
    assign o_saliency     = r_o_sal;
    assign o_out_of_range = r_o_oor;

    a_sweep_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep |-> (r_i >= r_rb0[0] && r_i <= r_rb1[0]
                      && r_j >= r_cb0[0] && r_j <= r_cb1[0]))
        else $error("sweep address left the outer window");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_a2))
        else $error("divider remainder not below divisor");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_oor) |-> (r_o_sal == '0))
        else $error("out of range result carries nonzero saliency");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> !$rose(r_o_valid))
        else $error("load produced a result");

endmodule

@@ rtl/multiscale_contrast_saliency.sv @@
// top level: config registers, channel hookup, controller and datapath
// depends on mcs_pkg, mcs_ifs, mcs_ctrl, mcs_dp
//
// usage
//   i_pix carries load and query items; o_sal carries one result per query.
//   a load writes L, a, b of one pixel into the image memory in the transfer
//   cycle and produces no result; the next item is taken in the next cycle.
//   a query sweeps the outer (largest) clipped window one pixel per cycle,
//   accumulating all three window sums at once, then for each scale squares
//   the area, multiplies, subtracts and squares per channel, sets up the
//   divider and runs a bit-serial restoring divide before accumulating.
//   the outer window is at most 65 by 65 pixels; an out of range query
//   skips the sweep and the math and returns a zero result.
//   queries do not overlap: no new item is taken until the previous query
//   has finished. reads of the apb registers return the stored value.
//   the user must write image_rows at byte 0 and image_cols at byte 4
//   over the apb port only while the block is idle; the block does not
//   enforce this. reset sets both sizes to 256 and empties the result
//   register; memory contents are undefined until written.
//   results sit in an output register; a new item is accepted while it waits,
//   and a finished query holds until the receiver takes the previous result.
module multiscale_contrast_saliency (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mcs_pix_if.sink                       i_pix,
    mcs_sal_if.source                     o_sal,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [mcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [mcs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import mcs_pkg::*;

    logic [REG_W-1:0] r_image_rows;
    logic [REG_W-1:0] r_image_cols;
    logic             reg_sel;
    t_cmd             cmd;
    t_stat            stat;
    logic             in_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= REG_W'(MAX_ROWS);
            r_image_cols <= REG_W'(MAX_COLS);
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_ROWS: r_image_rows <= pwdata[REG_W-1:0];
                REG_COLS: r_image_cols <= pwdata[REG_W-1:0];
                default:  r_image_rows <= r_image_rows;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROWS: prdata = PDATA_W'(r_image_rows);
            REG_COLS: prdata = PDATA_W'(r_image_cols);
            default:  prdata = '0;
        endcase
    end

    assign i_pix.ready = in_ready;

    mcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_action (i_pix.action),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd)
    );

    mcs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_rows         (r_image_rows),
        .i_cols         (r_image_cols),
        .i_pixel_row    (i_pix.pixel_row),
        .i_pixel_col    (i_pix.pixel_col),
        .i_lightness    (i_pix.lightness),
        .i_chroma_a     (i_pix.chroma_a),
        .i_chroma_b     (i_pix.chroma_b),
        .i_out_ready    (o_sal.ready),
        .o_out_valid    (o_sal.valid),
        .o_saliency     (o_sal.saliency),
        .o_out_of_range (o_sal.out_of_range)
    );

endmodule
